### rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the streaming prime sieve.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int          CELLS_DEF      = 256;
    localparam int          VALUE_BITS_DEF = 20;
    localparam int          LIMIT_W        = 21;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd480000;
    localparam int unsigned FIRST_VALUE    = 2;

    // Per-beat control flags that travel down the cell chain with the value
    typedef struct packed {
        logic valid;
        logic restart;
        logic done;
        logic last;
        logic sq_ok;
        logic composite;
        logic placed;
    } t_flags;

endpackage

### rtl/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell
// One sieve cell: holds a sieving prime and its next multiple, checks the
// passing value, claims itself for a new prime and forwards the beat.
// ----------------------------------------------------------------------------
module pss_cell #(
    parameter int VALUE_BITS = pss_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  pss_pkg::t_flags       i_flags,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [VALUE_BITS:0]   i_sq,
    output pss_pkg::t_flags       o_flags,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [VALUE_BITS:0]   o_sq
);
    import pss_pkg::*;

    localparam int PW = (VALUE_BITS + 1) / 2;
    localparam int MW = VALUE_BITS + 1;

    logic          r_vld;
    logic [PW-1:0] r_prime;
    logic [MW-1:0] r_mult;
    t_flags        r_flags;
    logic [VALUE_BITS-1:0] r_value;
    logic [MW-1:0] r_sq;

    logic   vld_eff;
    logic   hit;
    logic   alloc;
    t_flags n_flags;

    always_comb begin
        vld_eff = r_vld & ~i_flags.restart;
        hit     = vld_eff & ~i_flags.done & (r_mult == {1'b0, i_value});
        alloc   = ~vld_eff & ~i_flags.done & ~i_flags.composite
                  & ~i_flags.placed & i_flags.sq_ok;
        n_flags = i_flags;
        n_flags.composite = i_flags.composite | hit;
        n_flags.placed    = i_flags.placed | alloc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= n_flags;
            if (i_flags.valid) begin
                r_vld <= vld_eff | alloc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_value;
            r_sq    <= i_sq;
            if (i_flags.valid && hit) begin
                r_mult <= r_mult + MW'(r_prime);
            end else if (i_flags.valid && alloc) begin
                r_prime <= i_value[PW-1:0];
                r_mult  <= i_sq;
            end
        end
    end

    assign o_flags = r_flags;
    assign o_value = r_value;
    assign o_sq    = r_sq;

endmodule

### rtl/prime_sieve_stream.sv
// ----------------------------------------------------------------------------
// prime_sieve_stream
// Incremental sieve of Eratosthenes over 2 .. limit-1 on a chain of cells.
// ----------------------------------------------------------------------------
// Each input beat either restarts at 2 (tdata bit 0 set) or steps to the next
// value; one result beat comes out per input beat, in order. The block takes
// one beat per clock cycle while the output side does not stall; a beat walks
// through a head register, one stage per sieve cell and the output register,
// which presents its result. A stall on the output holds the whole chain.
// Every sieving prime p with p*p below limit occupies one cell; when none is
// free the sticky overflow bit is set and later composites of that prime may
// show as prime. Once stepping passes limit-1, every beat reports done with
// value 0 until a restart. Write the limit register only while no beat is in
// flight.
// ----------------------------------------------------------------------------
module prime_sieve_stream #(
    parameter int CELLS      = pss_pkg::CELLS_DEF,
    parameter int VALUE_BITS = pss_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [pss_pkg::LIMIT_W-1:0]  i_cfg_wr_data,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // [0] restart
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // value, is_prime, done_res, overflow from bit 0 up, zero filled
    output logic [((VALUE_BITS+3+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                         o_m_axis_tlast   // last
);
    import pss_pkg::*;

    localparam int PW    = (VALUE_BITS + 1) / 2;
    localparam int MW    = VALUE_BITS + 1;
    localparam int SW    = 2 * PW;
    localparam int LW    = (VALUE_BITS + 1 > LIMIT_W) ? VALUE_BITS + 1 : LIMIT_W;
    localparam int CW    = (LW > SW) ? LW : SW;
    localparam int OUT_W = ((VALUE_BITS + 3 + 7) / 8) * 8;

    logic [LIMIT_W-1:0]    r_limit;
    logic [VALUE_BITS-1:0] r_cur;
    logic                  r_fin;
    logic                  r_ovf;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_last;

    t_flags                s_flags [CELLS+1];
    logic [VALUE_BITS-1:0] s_value [CELLS+1];
    logic [MW-1:0]         s_sq    [CELLS+1];

    logic          en;
    logic          accept;
    logic          restart;
    logic [LW-1:0] lim_ext;
    logic [LW-1:0] span;
    logic [LW-1:0] lim_eff;
    logic [MW-1:0] v_full;
    logic          done;
    logic          last;
    logic [PW-1:0] v_lo;
    logic [SW-1:0] sq;
    logic          sq_ok;
    t_flags        tail;
    logic          ovf_new;
    logic          n_ovf;

    assign en              = ~r_out_valid | i_m_axis_tready;
    assign accept          = en & i_s_axis_tvalid;
    assign o_s_axis_tready = en;

    always_comb begin
        restart = i_s_axis_tdata[0];
        lim_ext = LW'(r_limit);
        span    = LW'(1) << VALUE_BITS;
        lim_eff = (lim_ext > span) ? span : lim_ext;
        v_full  = restart ? MW'(FIRST_VALUE) : MW'(r_cur) + MW'(1);
        done    = (r_fin & ~restart) | (LW'(v_full) >= lim_eff);
        last    = LW'(v_full) == (lim_eff - LW'(1));
        v_lo    = v_full[PW-1:0];
        sq      = SW'(v_lo) * SW'(v_lo);
        sq_ok   = ((v_full >> PW) == '0) && (CW'(sq) < CW'(lim_eff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= VALUE_BITS'(1);
            r_fin <= 1'b0;
        end else if (accept) begin
            r_fin <= done;
            if (!done) begin
                r_cur <= v_full[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_flags[0] <= '0;
        end else if (en) begin
            s_flags[0].valid     <= i_s_axis_tvalid;
            s_flags[0].restart   <= restart;
            s_flags[0].done      <= done;
            s_flags[0].last      <= last;
            s_flags[0].sq_ok     <= sq_ok;
            s_flags[0].composite <= 1'b0;
            s_flags[0].placed    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            s_value[0] <= v_full[VALUE_BITS-1:0];
            s_sq[0]    <= MW'(sq);
        end
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        pss_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_flags (s_flags[k]),
            .i_value (s_value[k]),
            .i_sq    (s_sq[k]),
            .o_flags (s_flags[k+1]),
            .o_value (s_value[k+1]),
            .o_sq    (s_sq[k+1])
        );
    end

    always_comb begin
        tail    = s_flags[CELLS];
        ovf_new = ~tail.done & ~tail.composite & tail.sq_ok & ~tail.placed;
        n_ovf   = (r_ovf & ~tail.restart) | ovf_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (en) begin
            r_out_valid <= tail.valid;
            if (tail.valid) begin
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && tail.valid) begin
            r_out_data <= OUT_W'({n_ovf, tail.done, ~tail.done & ~tail.composite,
                                  tail.done ? VALUE_BITS'(0) : s_value[CELLS]});
            r_out_last <= ~tail.done & tail.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

### tb/sv/tb_prime_sieve_stream.sv
// ----------------------------------------------------------------------------
// tb_prime_sieve_stream
// Self-checking testbench of the streaming prime sieve.
// ----------------------------------------------------------------------------
// Step beats go in under random bursts and gaps, and the output side stalls
// on its own pattern. Each accepted step runs through a behavioral sieve held
// in the testbench. Every result beat is compared field by field with the
// oldest prediction. Directed tests cover the reset limit, the smallest
// limit, a walk to the last value and past it, and a limit lowered under the
// stream. A long output hold fills the cell chain. Random phases then mix
// limits from the smallest to the largest with occasional restarts.
// ----------------------------------------------------------------------------
module tb_prime_sieve_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    localparam int CELLS     = CELLS_DEF;
    localparam int VB        = VALUE_BITS_DEF;
    localparam int OUT_W     = ((VB + 3 + 7) / 8) * 8;
    localparam int NUM_ITEMS = 1750;
    localparam int IDLE_MAX  = 5000;
    localparam longint unsigned SPAN = longint'(1) << VB;

    typedef struct packed {
        logic [VB-1:0] value;
        logic          is_prime;
        logic          last;
        logic          done_res;
        logic          overflow;
    } t_sieve_res;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [LIMIT_W-1:0]  i_cfg_wr_data;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_W-1:0]    o_m_axis_tdata;
    logic                o_m_axis_tlast;

    // sieve state mirrored from the block
    logic [LIMIT_W-1:0]  sv_limit;
    longint unsigned     sv_cur;
    longint unsigned     sv_prime [CELLS];
    longint unsigned     sv_next [CELLS];
    bit                  sv_used [CELLS];
    bit                  sv_finished;
    bit                  sv_ovf;

    t_sieve_res          sieve_verdicts_q[$];
    int                  err_count;
    int                  items_sent;
    int                  burst_left;
    bit                  tx_no_idle;
    bit                  rx_no_stall;
    int                  rx_hold_left;
    int                  idle_cycles;

    prime_sieve_stream #(
        .CELLS      (CELLS),
        .VALUE_BITS (VB)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [0] restart
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // value, is_prime, done_res, overflow
        .o_m_axis_tlast  (o_m_axis_tlast)    // last
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void sieve_clear();
        for (int i = 0; i < CELLS; i++) begin
            sv_prime[i] = 0;
            sv_next[i]  = 0;
            sv_used[i]  = 1'b0;
        end
    endfunction

    function automatic void sieve_advance(input logic restart, output t_sieve_res r);
        longint unsigned lim;
        longint unsigned v;
        bit              composite;
        bit              prime;
        bit              placed;
        lim       = (longint'(sv_limit) > SPAN) ? SPAN : longint'(sv_limit);
        composite = 1'b0;
        placed    = 1'b0;
        if (restart) begin
            sieve_clear();
            sv_finished = 1'b0;
            sv_ovf      = 1'b0;
            v           = FIRST_VALUE;
        end else begin
            v = sv_cur + 1;
        end
        if (sv_finished || v >= lim) begin
            sv_finished = 1'b1;
            r = '{value: '0, is_prime: 1'b0, last: 1'b0, done_res: 1'b1, overflow: sv_ovf};
            return;
        end
        sv_cur = v;
        for (int i = 0; i < CELLS; i++) begin
            if (sv_used[i] && sv_next[i] == v) begin
                composite  = 1'b1;
                sv_next[i] = sv_next[i] + sv_prime[i];
            end
        end
        prime = !composite && v >= FIRST_VALUE;
        if (prime && v * v < lim) begin
            for (int i = 0; i < CELLS && !placed; i++) begin
                if (!sv_used[i]) begin
                    sv_used[i]  = 1'b1;
                    sv_prime[i] = v;
                    sv_next[i]  = v * v;
                    placed      = 1'b1;
                end
            end
            if (!placed) begin
                sv_ovf = 1'b1;
            end
        end
        r.value    = v[VB-1:0];
        r.is_prime = prime;
        r.last     = (v == lim - 1);
        r.done_res = 1'b0;
        r.overflow = sv_ovf;
    endfunction

    task automatic send_step(input logic restart);
        int         gap;
        t_sieve_res r;
        if (!tx_no_idle && burst_left <= 0) begin
            burst_left = $urandom_range(32, 1);
            gap        = $urandom_range(6, 0);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'd0, restart};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sieve_advance(restart, r);
        sieve_verdicts_q = {sieve_verdicts_q, r};
        items_sent++;
        burst_left--;
    endtask

    task automatic send_run(input int count, input int restart_odds);
        for (int i = 0; i < count; i++) begin
            send_step(restart_odds > 0 && $urandom_range(restart_odds - 1, 0) == 0);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sieve_verdicts_q.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = lim;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sv_limit      = lim;
    endtask

    task automatic test_default_limit();
        repeat (6) send_step(1'b0);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        drain();
    endtask

    task automatic test_minimum_limit();
        write_limit(LIMIT_W'(3));
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        drain();
    endtask

    task automatic test_run_to_done();
        write_limit(LIMIT_W'(12));
        send_step(1'b1);
        repeat (11) send_step(1'b0);
        drain();
    endtask

    task automatic test_limit_shrink();
        write_limit(LIMIT_W'(200));
        send_step(1'b1);
        repeat (40) send_step(1'b0);
        drain();
        write_limit(LIMIT_W'(30));
        repeat (3) send_step(1'b0);
        send_step(1'b1);
        repeat (5) send_step(1'b0);
        drain();
        write_limit(LIMIT_W'(SPAN));
        send_step(1'b1);
        repeat (5) send_step(1'b0);
        drain();
    endtask

    task automatic test_output_hold();
        write_limit(LIMIT_W'(SPAN));
        tx_no_idle = 1'b1;
        @(posedge i_clk);
        rx_hold_left = 4 * CELLS;
        send_step(1'b1);
        send_run(3 * CELLS / 2, 0);
        drain();
        tx_no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        int pick;
        while (items_sent < NUM_ITEMS) begin
            drain();
            tx_no_idle  = ($urandom_range(4, 0) == 0);
            rx_no_stall = ($urandom_range(4, 0) == 0);
            if ($urandom_range(4, 0) != 0) begin
                pick = $urandom_range(99, 0);
                if (pick < 10) begin
                    write_limit(LIMIT_W'(3));
                end else if (pick < 20) begin
                    write_limit(LIMIT_W'(SPAN));
                end else if (pick < 35) begin
                    write_limit(LIMIT_W'($urandom_range(5000, 400)));
                end else begin
                    write_limit(LIMIT_W'($urandom_range(200, 4)));
                end
            end
            send_step(1'($urandom_range(1, 0)));
            send_run($urandom_range(150, 20), 64);
        end
        drain();
    endtask

    // receiver: own stall pattern, no stall at all when asked, or a long hold when asked
    initial begin
        int run_left;
        run_left        = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_m_axis_tready = 1'b0;
                rx_hold_left--;
            end else if (rx_no_stall) begin
                i_m_axis_tready = 1'b1;
            end else if (run_left <= 0) begin
                i_m_axis_tready = ($urandom_range(2, 0) != 0);
                run_left = i_m_axis_tready ? $urandom_range(20, 1) : $urandom_range(6, 1);
            end else begin
                run_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sieve_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (sieve_verdicts_q.size() == 0) begin
                $display("%0t: result beat with none pending, tdata 0x%0h tlast %0b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                err_count++;
            end else begin
                want = sieve_verdicts_q.pop_front();
                if (o_m_axis_tdata[VB-1:0] !== want.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, o_m_axis_tdata[VB-1:0]);
                    err_count++;
                end
                if (o_m_axis_tdata[VB] !== want.is_prime) begin
                    $display("%0t: is_prime of %0d expected %0b actual %0b",
                             $time, want.value, want.is_prime, o_m_axis_tdata[VB]);
                    err_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last of %0d expected %0b actual %0b",
                             $time, want.value, want.last, o_m_axis_tlast);
                    err_count++;
                end
                if (o_m_axis_tdata[VB+1] !== want.done_res) begin
                    $display("%0t: done_res of %0d expected %0b actual %0b",
                             $time, want.value, want.done_res, o_m_axis_tdata[VB+1]);
                    err_count++;
                end
                if (o_m_axis_tdata[VB+2] !== want.overflow) begin
                    $display("%0t: overflow of %0d expected %0b actual %0b",
                             $time, want.value, want.overflow, o_m_axis_tdata[VB+2]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_MAX);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        err_count       = 0;
        items_sent      = 0;
        burst_left      = 0;
        tx_no_idle      = 1'b0;
        rx_no_stall     = 1'b0;
        rx_hold_left    = 0;
        idle_cycles     = 0;
        sv_limit        = LIMIT_RESET;
        sv_cur          = 1;
        sv_finished     = 1'b0;
        sv_ovf          = 1'b0;
        sieve_clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_limit();
        test_minimum_limit();
        test_run_to_done();
        test_limit_shrink();
        test_output_hold();
        test_random_phases();

        drain();
        repeat (CELLS + 4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
